/* src/frame_timer_table_macros.svh */
// Assertion macros used by the frame timer table engine.
`ifndef FRAME_TIMER_TABLE_MACROS_SVH
`define FRAME_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FTT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ftt_pkg.sv */
// Shared constants, codes and types of the frame timer table.
`timescale 1ns / 1ps

package ftt_pkg;

   // Table size and derived widths
   localparam int NUM_SLOTS = 16;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   // Field widths
   localparam int CMD_W  = 2;
   localparam int DATA_W = 32;
   localparam int KIND_W = 2;
   localparam int SLOT_W = 4;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // Command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_ADD,
      OP_CLEAR
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRED   = 2'd0,
      KIND_ADDED   = 2'd1,
      KIND_FULL    = 2'd2,
      KIND_CLEARED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // One decoded command
   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   interval;
      logic [DATA_W-1:0]   repeat_count;
   } entry_type;

   // Valid flag plus command, used on both sides of the queue
   typedef struct packed {
      logic       valid;
      entry_type  entry;
   } queue_word_type;

endpackage

/* src/ftt_channels.sv */
// Request and response channel interfaces of the frame timer table.
`timescale 1ns / 1ps

interface ftt_req_if;
   logic                          valid;
   logic                          ready;
   logic [ftt_pkg::CMD_W-1:0]     command;
   logic [ftt_pkg::DATA_W-1:0]    interval;
   logic [ftt_pkg::DATA_W-1:0]    repeat_count;

   modport source (output valid, command, interval, repeat_count, input ready);
   modport sink   (input valid, command, interval, repeat_count, output ready);
endinterface

interface ftt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ftt_pkg::KIND_W-1:0]    kind;
   logic [ftt_pkg::SLOT_W-1:0]    slot;
   logic                          last;

   modport source (output valid, kind, slot, last, input ready);
   modport sink   (input valid, kind, slot, last, output ready);
endinterface

/* src/ftt_front.sv */
// Front end: accepts request words and decodes them into queue commands.
`timescale 1ns / 1ps

module ftt_front (
   ftt_req_if.sink                   req,
   input  logic                      q_full,
   output ftt_pkg::queue_word_type   push
);

   logic             known;
   ftt_pkg::op_type  op;

   // Decode the command; the unused code is taken and dropped
   always_comb begin
      known = 1'b1;
      op    = ftt_pkg::OP_TICK;
      case (req.command)
         ftt_pkg::CMD_TICK: begin
            op = ftt_pkg::OP_TICK;
         end
         ftt_pkg::CMD_ADD: begin
            op = ftt_pkg::OP_ADD;
         end
         ftt_pkg::CMD_CLEAR: begin
            op = ftt_pkg::OP_CLEAR;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req.ready = !q_full;

   always_comb begin
      push.valid              = req.valid && !q_full && known;
      push.entry.op           = op;
      push.entry.interval     = req.interval;
      push.entry.repeat_count = req.repeat_count;
   end

endmodule

/* src/ftt_queue.sv */
// Short command queue between the front end and the timer engine.
`timescale 1ns / 1ps

module ftt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ftt_pkg::queue_word_type   push,
   output logic                      full,
   output ftt_pkg::queue_word_type   head,
   input  logic                      pop
);

   ftt_pkg::entry_type               slots_ff [ftt_pkg::QDEPTH];
   logic [ftt_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ftt_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ftt_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   assign full    = (count_ff == ftt_pkg::QCNT_W'(ftt_pkg::QDEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

/* src/ftt_engine.sv */
// Timer engine: slot table, frame counter, slot scan and result register.
`timescale 1ns / 1ps
`include "frame_timer_table_macros.svh"

module ftt_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  ftt_pkg::queue_word_type   head,
   output logic                      pop,
   ftt_rsp_if.source                 rsp
);

   typedef struct packed {
      logic [ftt_pkg::DATA_W-1:0] interval;
      logic [ftt_pkg::DATA_W-1:0] deadline;
      logic [ftt_pkg::DATA_W-1:0] remaining;
   } slot_entry_type;

   // Slot storage, one port each for read and write
   slot_entry_type                    mem [ftt_pkg::NUM_SLOTS];
   slot_entry_type                    rd_data_ff;

   ftt_pkg::state_type                state_ff, state_in;
   logic [ftt_pkg::DATA_W-1:0]        frame_ff;
   logic [ftt_pkg::NUM_SLOTS-1:0]     valid_ff, forever_ff;
   logic [ftt_pkg::CNT_W-1:0]         rd_cnt_ff;
   logic                              ev_ff;
   logic [ftt_pkg::IDX_W-1:0]         ev_idx_ff;
   logic                              pend_ff;
   logic [ftt_pkg::IDX_W-1:0]         pend_idx_ff;
   logic                              out_valid_ff;
   ftt_pkg::kind_type                 out_kind_ff;
   logic [ftt_pkg::SLOT_W-1:0]        out_slot_ff;
   logic                              out_last_ff;

   logic                              out_free;
   logic                              any_free;
   logic [ftt_pkg::IDX_W-1:0]         free_idx;
   logic                              ev_fire;
   logic                              rd_more;
   logic                              scan_stall, scan_done, scan_go;
   logic [ftt_pkg::DATA_W-1:0]        rem_dec;

   // FSM outputs
   logic                              do_tick, do_add, do_clear, pend_clr;
   logic                              out_load, out_last_in;
   ftt_pkg::kind_type                 out_kind_in;
   logic [ftt_pkg::SLOT_W-1:0]        out_slot_in;

   // Memory write port
   logic                              wr_en;
   logic [ftt_pkg::IDX_W-1:0]         wr_addr;
   slot_entry_type                    wr_data;

   assign out_free = !out_valid_ff || rsp.ready;

   // Lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = ftt_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = ftt_pkg::IDX_W'(i);
         end
      end
   end

   // Evaluate stage of the scan
   assign ev_fire    = ev_ff && valid_ff[ev_idx_ff] && (frame_ff >= rd_data_ff.deadline);
   assign rem_dec    = rd_data_ff.remaining - 1'b1;
   assign rd_more    = (rd_cnt_ff < ftt_pkg::CNT_W'(ftt_pkg::NUM_SLOTS));
   assign scan_stall = ev_fire && pend_ff && !out_free;
   assign scan_done  = !rd_more && !ev_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ftt_pkg::ST_IDLE: begin
            if (head.valid && head.entry.op == ftt_pkg::OP_TICK) begin
               state_in = ftt_pkg::ST_SCAN;
            end
         end
         ftt_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = ftt_pkg::ST_FLUSH;
            end
         end
         ftt_pkg::ST_FLUSH: begin
            if (!pend_ff || out_free) begin
               state_in = ftt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ftt_pkg::ST_IDLE;
         end
      endcase
   end

   // FSM outputs
   always_comb begin
      pop         = 1'b0;
      do_tick     = 1'b0;
      do_add      = 1'b0;
      do_clear    = 1'b0;
      pend_clr    = 1'b0;
      scan_go     = 1'b0;
      out_load    = 1'b0;
      out_kind_in = ftt_pkg::KIND_FIRED;
      out_slot_in = '0;
      out_last_in = 1'b0;
      case (state_ff)
         ftt_pkg::ST_IDLE: begin
            if (head.valid) begin
               case (head.entry.op)
                  ftt_pkg::OP_TICK: begin
                     pop     = 1'b1;
                     do_tick = 1'b1;
                  end
                  ftt_pkg::OP_ADD: begin
                     if (out_free) begin
                        pop         = 1'b1;
                        do_add      = any_free;
                        out_load    = 1'b1;
                        out_last_in = 1'b1;
                        if (any_free) begin
                           out_kind_in = ftt_pkg::KIND_ADDED;
                           out_slot_in = ftt_pkg::SLOT_W'(free_idx);
                        end else begin
                           out_kind_in = ftt_pkg::KIND_FULL;
                        end
                     end
                  end
                  ftt_pkg::OP_CLEAR: begin
                     if (out_free) begin
                        pop         = 1'b1;
                        do_clear    = 1'b1;
                        out_load    = 1'b1;
                        out_last_in = 1'b1;
                        out_kind_in = ftt_pkg::KIND_CLEARED;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ftt_pkg::ST_SCAN: begin
            scan_go = !scan_stall && !scan_done;
            // A new firing releases the one held before it
            if (scan_go && ev_fire && pend_ff) begin
               out_load    = 1'b1;
               out_slot_in = ftt_pkg::SLOT_W'(pend_idx_ff);
            end
         end
         ftt_pkg::ST_FLUSH: begin
            if (pend_ff && out_free) begin
               out_load    = 1'b1;
               out_slot_in = ftt_pkg::SLOT_W'(pend_idx_ff);
               out_last_in = 1'b1;
               pend_clr    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Memory write selection: add or scan write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ev_idx_ff;
      wr_data = rd_data_ff;
      if (do_add) begin
         wr_en             = 1'b1;
         wr_addr           = free_idx;
         wr_data.interval  = head.entry.interval;
         wr_data.deadline  = frame_ff + head.entry.interval;
         wr_data.remaining = head.entry.repeat_count;
      end else if (scan_go && ev_fire) begin
         wr_en             = 1'b1;
         wr_data.deadline  = rd_data_ff.deadline + rd_data_ff.interval;
         if (!forever_ff[ev_idx_ff]) begin
            wr_data.remaining = rem_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (scan_go && rd_more) begin
         rd_data_ff <= mem[rd_cnt_ff[ftt_pkg::IDX_W-1:0]];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftt_pkg::ST_IDLE;
         frame_ff     <= '0;
         valid_ff     <= '0;
         forever_ff   <= '0;
         rd_cnt_ff    <= '0;
         ev_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_tick) begin
            frame_ff  <= frame_ff + 1'b1;
            rd_cnt_ff <= '0;
            ev_ff     <= 1'b0;
         end else if (scan_go) begin
            ev_ff <= rd_more;
            if (rd_more) begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
            end
         end
         if (do_clear) begin
            valid_ff   <= '0;
            forever_ff <= '0;
         end else if (do_add) begin
            valid_ff[free_idx]   <= 1'b1;
            forever_ff[free_idx] <= (head.entry.repeat_count == '0);
         end else if (scan_go && ev_fire && !forever_ff[ev_idx_ff] && rem_dec == '0) begin
            valid_ff[ev_idx_ff] <= 1'b0;
         end
         if (scan_go && ev_fire) begin
            pend_ff <= 1'b1;
         end else if (pend_clr) begin
            pend_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (scan_go && rd_more) begin
         ev_idx_ff <= rd_cnt_ff[ftt_pkg::IDX_W-1:0];
      end
      if (scan_go && ev_fire) begin
         pend_idx_ff <= ev_idx_ff;
      end
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_slot_ff <= out_slot_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.kind  = out_kind_ff;
   assign rsp.slot  = out_slot_ff;
   assign rsp.last  = out_last_ff;

   // Checks
   `FTT_ASSERT_SAME(a_pop_idle, pop, state_ff == ftt_pkg::ST_IDLE, "queue popped outside idle")
   `FTT_ASSERT_SAME(a_idle_no_pend, state_ff == ftt_pkg::ST_IDLE, !pend_ff, "held firing left in idle")
   `FTT_ASSERT_SAME(a_load_free, out_load, out_free, "result register overwritten")
   `FTT_ASSERT_NEXT(a_clear_empty, do_clear, valid_ff == '0, "table not empty after clear")
   `FTT_ASSERT_SAME(a_cnt_range, 1'b1, rd_cnt_ff <= ftt_pkg::CNT_W'(ftt_pkg::NUM_SLOTS), "scan counter out of range")

endmodule

/* src/frame_timer_table.sv */
// Top level of the frame timer table: front end, command queue and timer engine.
//
//   channel   dir  handshake      word
//   req_ch    in   valid/ready    command, interval, repeat_count
//   rsp_ch    out  valid/ready    kind, slot, last
//
// Add and clear are handled in the idle state of the engine; unused command words are dropped at the front.
// A tick runs through these steps: take, one read per slot, last compare,
// scan end and release of the last firing.
// A two-word command queue lets the request side take up to two words while the engine scans.
// Reset is synchronous and empties the table and the frame counter; no clearing pass.
// A stalled response holds the scan only when a second firing must be released.
`timescale 1ns / 1ps

module frame_timer_table (
   input  logic         clock,
   input  logic         reset,
   ftt_req_if.sink      req_ch,
   ftt_rsp_if.source    rsp_ch
);

   ftt_pkg::queue_word_type   push;
   ftt_pkg::queue_word_type   head;
   logic                      q_full;
   logic                      pop;

   ftt_front u_front (
      .req    (req_ch),
      .q_full (q_full),
      .push   (push)
   );

   ftt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .full   (q_full),
      .head   (head),
      .pop    (pop)
   );

   ftt_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp    (rsp_ch)
   );

endmodule

/* test/frame_timer_table_tb.sv */
// Self-checking testbench of the frame timer table: directed cases, random traffic, stalls.
`timescale 1ns / 1ps

module frame_timer_table_tb;

   // Command code the block drops without a result
   localparam logic [ftt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_WAIT  = 4 * ftt_pkg::NUM_SLOTS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      ftt_pkg::kind_type               kind;
      logic [ftt_pkg::SLOT_W-1:0]      slot;
      logic                            last;
   } table_event_type;

   logic clock;
   logic reset;

   ftt_req_if req_ch ();
   ftt_rsp_if rsp_ch ();

   frame_timer_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the timer table
   logic [ftt_pkg::DATA_W-1:0]     frame_now;
   logic [ftt_pkg::NUM_SLOTS-1:0]  tm_live;
   logic [ftt_pkg::NUM_SLOTS-1:0]  tm_forever;
   logic [ftt_pkg::DATA_W-1:0]     tm_interval  [ftt_pkg::NUM_SLOTS];
   logic [ftt_pkg::DATA_W-1:0]     tm_deadline  [ftt_pkg::NUM_SLOTS];
   logic [ftt_pkg::DATA_W-1:0]     tm_remaining [ftt_pkg::NUM_SLOTS];

   table_event_type owed_events [$];

   int mismatch_count = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   int hold_left      = 0;
   logic hold_active;

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Queue one expected result word
   function automatic void owe(input ftt_pkg::kind_type kind, input int idx, input bit fin);
      table_event_type ev;
      ev.kind = kind;
      ev.slot = ftt_pkg::SLOT_W'(idx);
      ev.last = fin;
      owed_events.push_back(ev);
   endfunction

   // Advance the shadow table by one accepted command and queue its results
   function automatic void apply_command(input logic [ftt_pkg::CMD_W-1:0]  cmd,
                                         input logic [ftt_pkg::DATA_W-1:0] ival,
                                         input logic [ftt_pkg::DATA_W-1:0] rep);
      logic [ftt_pkg::NUM_SLOTS-1:0] due;
      int top;
      int free_idx;
      due      = '0;
      top      = -1;
      free_idx = -1;
      case (cmd)
         ftt_pkg::CMD_TICK: begin
            frame_now = frame_now + 1'b1;
            for (int i = 0; i < ftt_pkg::NUM_SLOTS; i++) begin
               if (tm_live[i] && frame_now >= tm_deadline[i]) begin
                  due[i] = 1'b1;
                  top    = i;
                  tm_deadline[i] = tm_deadline[i] + tm_interval[i];
                  if (!tm_forever[i]) begin
                     tm_remaining[i] = tm_remaining[i] - 1'b1;
                     if (tm_remaining[i] == '0) tm_live[i] = 1'b0;
                  end
               end
            end
            for (int i = 0; i < ftt_pkg::NUM_SLOTS; i++)
               if (due[i]) owe(ftt_pkg::KIND_FIRED, i, i == top);
         end
         ftt_pkg::CMD_ADD: begin
            for (int i = ftt_pkg::NUM_SLOTS - 1; i >= 0; i--)
               if (!tm_live[i]) free_idx = i;
            if (free_idx < 0) begin
               owe(ftt_pkg::KIND_FULL, 0, 1'b1);
            end else begin
               tm_live[free_idx]      = 1'b1;
               tm_forever[free_idx]   = (rep == '0);
               tm_interval[free_idx]  = ival;
               tm_deadline[free_idx]  = frame_now + ival;
               tm_remaining[free_idx] = rep;
               owe(ftt_pkg::KIND_ADDED, free_idx, 1'b1);
            end
         end
         ftt_pkg::CMD_CLEAR: begin
            tm_live    = '0;
            tm_forever = '0;
            owe(ftt_pkg::KIND_CLEARED, 0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Offer one request word, with random idle cycles ahead of it
   task automatic send_word(input logic [ftt_pkg::CMD_W-1:0]  cmd,
                            input logic [ftt_pkg::DATA_W-1:0] ival,
                            input logic [ftt_pkg::DATA_W-1:0] rep);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.interval     <= ival;
      req_ch.repeat_count <= rep;
      do @(posedge clock); while (!req_ch.ready);
      apply_command(cmd, ival, rep);
   endtask

   // Stop offering and wait for every owed result word
   task automatic drain_events();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (owed_events.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus the long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
      end
   end

   // Hold-off counter, in clock cycles
   initial begin
      hold_active = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_active <= 1'b1;
            hold_left   <= hold_left - 1;
         end else begin
            hold_active <= 1'b0;
         end
      end
   end

   // Compare each response word with the oldest owed result
   always @(posedge clock) begin
      table_event_type exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected word kind=%0d slot=%0d last=%0d",
                        $realtime, rsp_ch.kind, rsp_ch.slot, rsp_ch.last);
         end else begin
            exp = owed_events.pop_front();
            if (rsp_ch.kind !== exp.kind || rsp_ch.slot !== exp.slot
                || rsp_ch.last !== exp.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: expected kind=%0d slot=%0d last=%0d, got %0d/%0d/%0d",
                           $realtime, exp.kind, exp.slot, exp.last,
                           rsp_ch.kind, rsp_ch.slot, rsp_ch.last);
            end
         end
      end
   end

   // Tick with nothing due, the unused command, clear on an empty table
   task automatic test_quiet_commands();
      send_word(ftt_pkg::CMD_TICK, '0, '0);
      send_word(CMD_UNUSED, '1, '1);
      send_word(ftt_pkg::CMD_CLEAR, '1, '0);
      drain_events();
   endtask

   // Forever timer at interval zero, deadline wrap, one-shot and two-shot timers
   task automatic test_firing_rules();
      send_word(ftt_pkg::CMD_ADD, '0, '0);
      send_word(ftt_pkg::CMD_ADD, '1, '1);
      send_word(ftt_pkg::CMD_ADD, 32'd1, 32'd1);
      send_word(ftt_pkg::CMD_TICK, '0, '0);
      send_word(ftt_pkg::CMD_ADD, 32'd2, 32'd2);
      send_word(ftt_pkg::CMD_TICK, '1, '1);
      send_word(ftt_pkg::CMD_TICK, '0, '0);
      drain_events();
   endtask

   // Fill every slot, add once more to a full table, then clear it
   task automatic test_full_table();
      while (!(&tm_live))
         send_word(ftt_pkg::CMD_ADD, $urandom, $urandom);
      send_word(ftt_pkg::CMD_ADD, 32'd3, 32'd3);
      send_word(ftt_pkg::CMD_CLEAR, '0, '0);
      drain_events();
   endtask

   // Mostly well-formed timer traffic with short intervals, some noise
   task automatic test_random_traffic(input int count);
      int pick;
      int sent;
      logic [ftt_pkg::CMD_W-1:0]  cmd;
      logic [ftt_pkg::DATA_W-1:0] ival;
      logic [ftt_pkg::DATA_W-1:0] rep;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         ival = $urandom;
         rep  = $urandom;
         if (pick < 50) begin
            cmd = ftt_pkg::CMD_TICK;
         end else if (pick < 88) begin
            cmd = ftt_pkg::CMD_ADD;
            if ($urandom_range(9) != 0) ival = $urandom_range(6);
            if ($urandom_range(9) != 0) rep  = $urandom_range(5);
         end else if (pick < 94) begin
            cmd = ftt_pkg::CMD_CLEAR;
         end else begin
            cmd = CMD_UNUSED;
         end
         send_word(cmd, ival, rep);
         if (cmd != CMD_UNUSED) sent++;
      end
      drain_events();
   endtask

   // Receiver holds off while busy ticks keep coming, so the input stalls
   task automatic test_backpressure();
      send_word(ftt_pkg::CMD_CLEAR, '0, '0);
      drain_events();
      @(negedge clock);
      hold_left = HOLD_CYCLES;
      repeat (4) send_word(ftt_pkg::CMD_ADD, '0, '0);
      repeat (10) send_word(ftt_pkg::CMD_TICK, $urandom, $urandom);
      send_word(ftt_pkg::CMD_CLEAR, '0, '0);
      drain_events();
   endtask

   // Test sequence
   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.command      = ftt_pkg::CMD_TICK;
      req_ch.interval     = '0;
      req_ch.repeat_count = '0;
      frame_now    = '0;
      tm_live      = '0;
      tm_forever   = '0;
      for (int i = 0; i < ftt_pkg::NUM_SLOTS; i++) begin
         tm_interval[i]  = '0;
         tm_deadline[i]  = '0;
         tm_remaining[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      gap_pct   = 6;
      stall_pct = 48;
      test_quiet_commands();
      test_firing_rules();
      test_full_table();
      test_random_traffic(38);

      gap_pct   = 48;
      stall_pct = 6;
      test_random_traffic(38);

      gap_pct   = 0;
      stall_pct = 0;
      test_random_traffic(38);
      test_backpressure();

      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0 && owed_events.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

/* frame_timer_table.f */
+incdir+src
src/ftt_pkg.sv
src/ftt_channels.sv
src/ftt_front.sv
src/ftt_queue.sv
src/ftt_engine.sv
src/frame_timer_table.sv
test/frame_timer_table_tb.sv
